/* rtl/scld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_pkg: shared types and constants for the serial command line decoder
// Character codes, response and motion codes, operating modes and the
// state and result records passed between the decoder core and its logic.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int DefLineCapacity = 10;
  localparam int CountW          = 4;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ESC = 8'h1B;

  localparam logic [7:0] CH_HELP   = 8'h68; // 'h'
  localparam logic [7:0] CH_MANUAL = 8'h6D; // 'm'
  localparam logic [7:0] CH_AUTO   = 8'h6F; // 'o'
  localparam logic [7:0] CH_DEBUG  = 8'h62; // 'b'
  localparam logic [7:0] CH_FWD    = 8'h61; // 'a'
  localparam logic [7:0] CH_BWD    = 8'h72; // 'r'
  localparam logic [7:0] CH_STOP   = 8'h73; // 's'
  localparam logic [7:0] CH_LEFT   = 8'h64; // 'd'
  localparam logic [7:0] CH_RIGHT  = 8'h67; // 'g'

  localparam logic [2:0] RSP_NONE    = 3'd0;
  localparam logic [2:0] RSP_HELP    = 3'd1;
  localparam logic [2:0] RSP_MODE    = 3'd2;
  localparam logic [2:0] RSP_MOTION  = 3'd3;
  localparam logic [2:0] RSP_UNKNOWN = 3'd4;

  localparam logic [2:0] MOT_NONE  = 3'd0;
  localparam logic [2:0] MOT_FWD   = 3'd1;
  localparam logic [2:0] MOT_BWD   = 3'd2;
  localparam logic [2:0] MOT_STOP  = 3'd3;
  localparam logic [2:0] MOT_LEFT  = 3'd4;
  localparam logic [2:0] MOT_RIGHT = 3'd5;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_DEBUG  = 2'd2;

  typedef struct packed {
    logic [CountW-1:0] char_count;
    logic [7:0]        first_char;
    logic [1:0]        operating_mode;
  } scld_state_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       line_done;
    logic [2:0] response;
    logic [2:0] motion;
    logic [1:0] current_mode;
  } scld_result_t;

endpackage

/* rtl/scld_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_decode: per-byte line editing and command decoding
// From the current line state and one received byte, computes the next
// line state and the result record for that byte.
// ----------------------------------------------------------------------------
module scld_decode
  import scld_pkg::*;
#(
  parameter int LINE_CAPACITY = DefLineCapacity
) (
  input  scld_state_t  state,
  input  logic [7:0]   rx_byte,
  output scld_state_t  state_next,
  output scld_result_t result
);

  localparam logic [CountW-1:0] Cap = CountW'(LINE_CAPACITY);

  logic       is_end;
  logic       is_erase;
  logic       single;
  logic [2:0] rsp;
  logic [2:0] mot;
  logic [1:0] mode_next;

  assign is_end   = (rx_byte == CH_ESC) || (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  // ESC discards the line, so it always decodes as an empty line.
  assign single   = (rx_byte != CH_ESC) && (state.char_count == CountW'(1));

  always_comb begin
    rsp       = RSP_UNKNOWN;
    mot       = MOT_NONE;
    mode_next = state.operating_mode;
    if (single && state.first_char == CH_HELP) begin
      rsp = RSP_HELP;
    end else if (single && state.first_char == CH_MANUAL) begin
      rsp       = RSP_MODE;
      mode_next = MODE_MANUAL;
    end else if (single && state.first_char == CH_AUTO) begin
      rsp       = RSP_MODE;
      mode_next = MODE_AUTO;
    end else if (single && state.first_char == CH_DEBUG) begin
      rsp       = RSP_MODE;
      mode_next = MODE_DEBUG;
    end else if (single && state.operating_mode == MODE_MANUAL) begin
      priority if (state.first_char == CH_FWD) begin
        mot = MOT_FWD;
      end else if (state.first_char == CH_BWD) begin
        mot = MOT_BWD;
      end else if (state.first_char == CH_STOP) begin
        mot = MOT_STOP;
      end else if (state.first_char == CH_LEFT) begin
        mot = MOT_LEFT;
      end else if (state.first_char == CH_RIGHT) begin
        mot = MOT_RIGHT;
      end else begin
        mot = MOT_NONE;
      end
      if (mot != MOT_NONE) begin
        rsp = RSP_MOTION;
      end
    end
  end

  always_comb begin
    state_next          = state;
    result.echo_byte    = rx_byte;
    result.line_done    = 1'b0;
    result.response     = RSP_NONE;
    result.motion       = MOT_NONE;
    priority if (is_end) begin
      state_next.char_count     = '0;
      state_next.operating_mode = mode_next;
      result.line_done          = 1'b1;
      result.response           = rsp;
      result.motion             = mot;
    end else if (is_erase) begin
      if (state.char_count != '0) begin
        state_next.char_count = state.char_count - CountW'(1);
      end
    end else if (state.char_count < Cap) begin
      if (state.char_count == '0) begin
        state_next.first_char = rx_byte;
      end
      state_next.char_count = state.char_count + CountW'(1);
    end else begin
      // A full line drops the character and loses one stored position.
      state_next.char_count = state.char_count - CountW'(1);
    end
    result.current_mode = state_next.operating_mode;
  end

endmodule

/* rtl/serial_command_line_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder_core: serial command line editor and decoder
// Echoes every received byte, keeps an editable command line and decodes
// finished lines into help, mode and motion responses.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on rx_byte with in_valid/in_ready. Each accepted
// request yields exactly one result on the output channel (out_valid/
// out_ready): the echoed byte, a line-done flag, the response and motion
// codes, and the operating mode after that byte.
// The byte is captured in an input register; the line editing and decoding
// logic then updates the line state and loads the output register, once
// that register is empty or its result is being taken. One byte is
// accepted per cycle while results are being taken.
// When the receiver stalls, the output register holds its result, the
// input register fills, and in_ready drops until out_ready returns.
// Reset empties the line, clears the stored first character, selects
// automatic mode and discards any byte in flight.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_core
  import scld_pkg::*;
#(
  parameter int LINE_CAPACITY = DefLineCapacity
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] echo_byte,
  output logic       line_done,
  output logic [2:0] response,
  output logic [2:0] motion,
  output logic [1:0] current_mode
);

  logic         in_reg_valid;
  logic [7:0]   in_reg_byte;
  logic         advance;
  scld_state_t  state;
  scld_state_t  state_next;
  scld_result_t result_next;
  scld_result_t out_reg;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  scld_decode #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_decode (
    .state      (state),
    .rx_byte    (in_reg_byte),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid         <= 1'b0;
      out_valid            <= 1'b0;
      state.char_count     <= '0;
      state.first_char     <= '0;
      state.operating_mode <= MODE_AUTO;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte <= rx_byte;
    end
    if (advance) begin
      out_reg <= result_next;
    end
  end

  assign echo_byte    = out_reg.echo_byte;
  assign line_done    = out_reg.line_done;
  assign response     = out_reg.response;
  assign motion       = out_reg.motion;
  assign current_mode = out_reg.current_mode;

  a_rsp_only_on_line_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_done |-> response == RSP_NONE && motion == MOT_NONE)
    else $error("response reported without a line end");

  a_motion_in_manual: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion != MOT_NONE |-> response == RSP_MOTION &&
                                        current_mode == MODE_MANUAL)
    else $error("motion reported outside manual mode");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state.char_count <= CountW'(LINE_CAPACITY))
    else $error("line count exceeds capacity");

  a_reset_mode: assert property (@(posedge clk)
    $past(rst) |-> state.operating_mode == MODE_AUTO && !out_valid)
    else $error("reset did not restore automatic mode");

endmodule
